// ===== sv/sls_pkg.sv =====
// Package for the sub-word load/store unit: item types, width and error codes.
// No dependencies; imported by sls_exec and subword_load_store_unit.
package sls_pkg;

    localparam int REG_COUNT = 32;

    typedef enum logic [0:0] {
        CMD_ISSUE    = 1'b0,
        CMD_RESPONSE = 1'b1
    } t_command;

    localparam logic [2:0] W_BYTE  = 3'd0;
    localparam logic [2:0] W_HALF  = 3'd1;
    localparam logic [2:0] W_WORD  = 3'd2;
    localparam logic [2:0] W_BYTEU = 3'd4;
    localparam logic [2:0] W_HALFU = 3'd5;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_MISALIGNED = 3'd1;
    localparam logic [2:0] ERR_WIDTH      = 3'd2;
    localparam logic [2:0] ERR_BUSY       = 3'd3;
    localparam logic [2:0] ERR_UNEXPECTED = 3'd4;

    typedef struct packed {
        logic        command;
        logic        is_store;
        logic [2:0]  width_code;
        logic [31:0] address;
        logic [31:0] store_data;
        logic [4:0]  dest_reg;
        logic [31:0] resume_pc_in;
        logic [31:0] resp_word;
    } t_in_item;

    typedef struct packed {
        logic        req_valid;
        logic        req_write;
        logic [31:0] req_addr;
        logic [31:0] req_wdata;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        done_res;
        logic [31:0] resume_pc;
        logic [2:0]  error_code;
    } t_out_item;

endpackage

// ===== sv/subword_load_store_unit.sv =====
// Top level of the sub-word load/store unit: input register, sequencer, result register.
// Depends on sls_pkg and sls_exec.
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+---------------------------------------------
//  in       | i_valid | o_ready | i_item   (issue or memory response item)
//  out      | o_valid | i_ready | o_result (request, load writeback, done, error)
//
// Every item yields exactly one result item. An accepted item waits in the input
// register; its result is then captured in the result register and presented.
// Sustained rate is one item per cycle while the output is not stalled; the
// pending-access state is updated as an item leaves the input register, so a
// following item sees it in the next cycle.
// Reset (synchronous, active low) empties both registers and returns to idle.
// A stall on the output holds the result register and, once the input register
// is also full, drops o_ready; nothing is lost or repeated.
module subword_load_store_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sls_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output sls_pkg::t_out_item o_result
);
    import sls_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item exec_result;
    logic      advance;

    // advance the held item whenever the result register is free or being emptied
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_result = r_out;

    sls_exec u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_result (exec_result)
    );

    // control: occupancy of the two registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: capture on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_item;
        end
        if (advance) begin
            r_out <= exec_result;
        end
    end

    // an error result carries nothing else
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.error_code != ERR_NONE |->
            !o_result.req_valid && !o_result.done_res && !o_result.reg_write)
        else $error("error result carries other fields");

    // requests are always word aligned
    a_req_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.req_valid |-> o_result.req_addr[1:0] == 2'b00)
        else $error("unaligned memory request");

    // a result never both issues a request and completes
    a_req_or_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.req_valid && o_result.done_res))
        else $error("request and completion in one result");

    // register writeback only on completion, never to register zero
    a_writeback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.reg_write |-> o_result.done_res && o_result.reg_index != 5'd0)
        else $error("bad register writeback");

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

// ===== sv/sls_exec.sv =====
// Access sequencer: pending-access state plus the decode, merge and extract logic.
// Depends on sls_pkg.
module sls_exec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  sls_pkg::t_in_item  i_item,
    output sls_pkg::t_out_item o_result
);
    import sls_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_LOAD     = 2'd1,
        PH_RMW_READ = 2'd2,
        PH_WRITE    = 2'd3
    } t_phase;

    localparam logic [5:0] REG_LIMIT = 6'(REG_COUNT);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_kind, n_kind;
    logic [4:0]  r_dest, n_dest;
    logic [31:0] r_addr, n_addr;
    logic [31:0] r_data, n_data;
    logic [31:0] r_mask, n_mask;
    logic [4:0]  r_shift, n_shift;
    logic [31:0] r_pc, n_pc;

    logic        ok_width;
    logic        misaligned;
    logic [4:0]  lane_shift;
    logic [31:0] lane_word;
    logic [31:0] merged;
    logic [31:0] load_value;

    // narrow the response to the pending width, then extend
    always_comb begin
        lane_shift = (r_kind == W_HALF || r_kind == W_HALFU) ? {r_addr[1], 4'b0000}
                                                             : {r_addr[1:0], 3'b000};
        lane_word  = i_item.resp_word >> lane_shift;
        case (r_kind)
            W_BYTE:  load_value = {{24{lane_word[7]}}, lane_word[7:0]};
            W_HALF:  load_value = {{16{lane_word[15]}}, lane_word[15:0]};
            W_BYTEU: load_value = {24'd0, lane_word[7:0]};
            W_HALFU: load_value = {16'd0, lane_word[15:0]};
            default: load_value = i_item.resp_word;
        endcase
    end

    assign merged = (i_item.resp_word & ~r_mask) | ((r_data << r_shift) & r_mask);

    always_comb begin
        ok_width   = (i_item.width_code <= W_WORD) ||
                     (!i_item.is_store &&
                      (i_item.width_code == W_BYTEU || i_item.width_code == W_HALFU));
        misaligned = ((i_item.width_code == W_HALF || i_item.width_code == W_HALFU) &&
                      i_item.address[0]) ||
                     (i_item.width_code == W_WORD && i_item.address[1:0] != 2'b00);

        o_result = '0;
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_dest   = r_dest;
        n_addr   = r_addr;
        n_data   = r_data;
        n_mask   = r_mask;
        n_shift  = r_shift;
        n_pc     = r_pc;

        if (i_item.command == CMD_ISSUE) begin
            if (r_phase != PH_IDLE) begin
                o_result.error_code = ERR_BUSY;
            end else if (!ok_width) begin
                o_result.error_code = ERR_WIDTH;
            end else if (misaligned) begin
                o_result.error_code = ERR_MISALIGNED;
            end else begin
                n_kind             = i_item.width_code;
                n_addr             = i_item.address;
                n_pc               = i_item.resume_pc_in;
                o_result.req_valid = 1'b1;
                o_result.req_addr  = {i_item.address[31:2], 2'b00};
                if (!i_item.is_store) begin
                    n_dest  = i_item.dest_reg;
                    n_data  = '0;
                    n_mask  = '0;
                    n_shift = '0;
                    n_phase = PH_LOAD;
                end else begin
                    n_dest = '0;
                    if (i_item.width_code == W_WORD) begin
                        n_data             = i_item.store_data;
                        n_mask             = '1;
                        n_shift            = '0;
                        n_phase            = PH_WRITE;
                        o_result.req_write = 1'b1;
                        o_result.req_wdata = i_item.store_data;
                    end else if (i_item.width_code == W_BYTE) begin
                        n_data  = {24'd0, i_item.store_data[7:0]};
                        n_shift = {i_item.address[1:0], 3'b000};
                        n_mask  = 32'h0000_00ff << n_shift;
                        n_phase = PH_RMW_READ;
                    end else begin
                        n_data  = {16'd0, i_item.store_data[15:0]};
                        n_shift = {i_item.address[1], 4'b0000};
                        n_mask  = 32'h0000_ffff << n_shift;
                        n_phase = PH_RMW_READ;
                    end
                end
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    o_result.error_code = ERR_UNEXPECTED;
                end
                PH_RMW_READ: begin
                    o_result.req_valid = 1'b1;
                    o_result.req_write = 1'b1;
                    o_result.req_addr  = {r_addr[31:2], 2'b00};
                    o_result.req_wdata = merged;
                    n_data             = merged;
                    n_phase            = PH_WRITE;
                end
                default: begin
                    if (r_phase == PH_LOAD) begin
                        o_result.reg_write = (r_dest != 5'd0) && ({1'b0, r_dest} < REG_LIMIT);
                        o_result.reg_index = r_dest;
                        o_result.reg_value = load_value;
                    end
                    o_result.done_res  = 1'b1;
                    o_result.resume_pc = r_pc;
                    // drop the finished access
                    n_phase = PH_IDLE;
                    n_kind  = '0;
                    n_dest  = '0;
                    n_addr  = '0;
                    n_data  = '0;
                    n_mask  = '0;
                    n_shift = '0;
                    n_pc    = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= '0;
            r_dest  <= '0;
            r_addr  <= '0;
            r_data  <= '0;
            r_mask  <= '0;
            r_shift <= '0;
            r_pc    <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_dest  <= n_dest;
            r_addr  <= n_addr;
            r_data  <= n_data;
            r_mask  <= n_mask;
            r_shift <= n_shift;
            r_pc    <= n_pc;
        end
    end

endmodule
